// ----- rtl/dssc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dssc_pkg
// Shared constants of the diagnostic session and service gate: event codes,
// response codes, register indexes, reset limits and stream word layout.
// ----------------------------------------------------------------------------
package dssc_pkg;

  // Event codes carried in tuser
  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_REQUEST     = 3'd1;
  localparam logic [2:0] CMD_SET_SESSION = 3'd2;
  localparam logic [2:0] CMD_HEARTBEAT   = 3'd3;
  localparam logic [2:0] CMD_RESPONSE    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_P2_DEFAULT      = 2'd0;
  localparam logic [1:0] CFG_P2_STAR_DEFAULT = 2'd1;
  localparam logic [1:0] CFG_S3_LIMIT        = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] P2_DEFAULT_RST      = 16'd100;
  localparam logic [15:0] P2_STAR_DEFAULT_RST = 16'd300;
  localparam logic [15:0] S3_LIMIT_RST        = 16'd5000;

  // Service ids and negative response codes
  localparam logic [7:0] SID_TESTER_PRESENT = 8'h3E;
  localparam logic [7:0] RESPONSE_BIT       = 8'h40;
  localparam logic [7:0] NRC_NONE           = 8'h00;
  localparam logic [7:0] NRC_NOT_SUPPORTED  = 8'h11;
  localparam logic [7:0] NRC_NOT_IN_SESSION = 8'h7F;
  localparam logic [7:0] NRC_BUSY           = 8'h21;
  localparam logic [7:0] NRC_PENDING        = 8'h78;

  localparam logic [2:0]  SESSION_DEFAULT = 3'd0;
  localparam logic [15:0] AGE_MAX         = 16'hFFFF;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [2:0] active_session;
    logic       run_service;
    logic [7:0] nrc_sid;
    logic [7:0] nrc_code;
    logic       send_nrc;
  } result_t;

  function automatic logic [15:0] age_up(input logic [15:0] a);
    age_up = (a == AGE_MAX) ? AGE_MAX : a + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/diag_session_service_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// diag_session_service_control
// Diagnostic session and service gate: session timeout, busy / not supported /
// not in session checks, and response pending reminders, one event per word.
// ----------------------------------------------------------------------------
// Result: state and result register are written at the edge that accepts the
//   input word (the result goes to the skid word while the output stalls).
// Throughput: 1 word per cycle; a two-entry result buffer (output register
//   plus skid) keeps the input open for one word while the output stalls.
// Reset: rst_ni asynchronous, active low; default session, default limits,
//   no pending service, output empty.
module diag_session_service_control (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output      logic                                s_axis_tready_o,
  // [7:0] first_byte, [8] service_known, [16:9] session_mask,
  // [17] service_outcome, [20:18] new_session, [36:21] new_p2,
  // [52:37] new_p2_star, [55:53] zero
  input  wire logic [dssc_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [2:0] command
  input  wire logic [2:0]                          s_axis_tuser_i,
  output      logic                                m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [0] send_nrc, [8:1] nrc_code, [16:9] nrc_sid, [17] run_service,
  // [20:18] active_session, [23:21] zero
  output      logic [dssc_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [dssc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dssc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Input word fields
  logic [7:0]  first_byte;
  logic        service_known;
  logic [7:0]  session_mask;
  logic        service_outcome;
  logic [2:0]  new_session;
  logic [15:0] new_p2;
  logic [15:0] new_p2_star;

  assign first_byte      = s_axis_tdata_i[7:0];
  assign service_known   = s_axis_tdata_i[8];
  assign session_mask    = s_axis_tdata_i[16:9];
  assign service_outcome = s_axis_tdata_i[17];
  assign new_session     = s_axis_tdata_i[20:18];
  assign new_p2          = s_axis_tdata_i[36:21];
  assign new_p2_star     = s_axis_tdata_i[52:37];

  // Configuration and state
  logic [15:0] p2_default_q, p2_star_default_q, s3_limit_q;
  logic [2:0]  session_q, session_d;
  logic [15:0] p2_limit_q, p2_limit_d;
  logic [15:0] p2_star_limit_q, p2_star_limit_d;
  logic [15:0] session_age_q, session_age_d;
  logic        pending_active_q, pending_active_d;
  logic [7:0]  pending_sid_q, pending_sid_d;
  logic [15:0] pending_age_q, pending_age_d;
  logic        p2_passed_q, p2_passed_d;

  // Result buffer
  dssc_pkg::result_t res_d, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  logic        in_accept, out_take, cfg_write;
  logic [15:0] sa_inc, pa_inc, pend_limit;
  logic        fallback, allowed;

  assign cfg_ready_o     = 1'b1;
  assign cfg_write       = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = ~skid_valid_q;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign out_take        = out_valid_q & m_axis_tready_i;
  assign m_axis_tdata_o  = {3'b000, out_q};

  assign sa_inc   = dssc_pkg::age_up(session_age_q);
  assign pa_inc   = dssc_pkg::age_up(pending_age_q);
  assign fallback = (session_q != dssc_pkg::SESSION_DEFAULT) && (sa_inc >= s3_limit_q);
  // limits after a possible fallback in the same tick
  assign pend_limit = p2_passed_q ? (fallback ? p2_star_default_q : p2_star_limit_q)
                                  : (fallback ? p2_default_q : p2_limit_q);
  assign allowed  = session_mask[session_q];

  always_comb begin
    session_d        = session_q;
    p2_limit_d       = p2_limit_q;
    p2_star_limit_d  = p2_star_limit_q;
    session_age_d    = session_age_q;
    pending_active_d = pending_active_q;
    pending_sid_d    = pending_sid_q;
    pending_age_d    = pending_age_q;
    p2_passed_d      = p2_passed_q;
    res_d            = '0;

    case (s_axis_tuser_i)
      dssc_pkg::CMD_TICK: begin
        session_age_d = sa_inc;
        pending_age_d = pa_inc;
        if (fallback) begin
          session_d       = dssc_pkg::SESSION_DEFAULT;
          p2_limit_d      = p2_default_q;
          p2_star_limit_d = p2_star_default_q;
        end
        if (pending_active_q) begin
          if (pa_inc >= pend_limit) begin
            p2_passed_d    = 1'b1;
            res_d.send_nrc = 1'b1;
            res_d.nrc_code = dssc_pkg::NRC_PENDING;
            res_d.nrc_sid  = pending_sid_q;
            pending_age_d  = '0;
          end
        end else begin
          p2_passed_d = 1'b0;
        end
      end
      dssc_pkg::CMD_REQUEST: begin
        if (!pending_active_q || first_byte == dssc_pkg::SID_TESTER_PRESENT) begin
          if (!service_known) begin
            res_d.send_nrc = 1'b1;
            res_d.nrc_code = dssc_pkg::NRC_NOT_SUPPORTED;
            res_d.nrc_sid  = first_byte;
          end else if (allowed) begin
            res_d.run_service = 1'b1;
            if (service_outcome) begin
              pending_active_d = 1'b1;
              pending_sid_d    = first_byte;
              pending_age_d    = '0;
            end
          end else begin
            res_d.send_nrc = 1'b1;
            res_d.nrc_code = dssc_pkg::NRC_NOT_IN_SESSION;
            res_d.nrc_sid  = first_byte;
          end
        end else begin
          res_d.send_nrc = 1'b1;
          res_d.nrc_code = dssc_pkg::NRC_BUSY;
          res_d.nrc_sid  = first_byte;
        end
      end
      dssc_pkg::CMD_SET_SESSION: begin
        session_d = new_session;
        if (new_session != dssc_pkg::SESSION_DEFAULT) begin
          session_age_d   = '0;
          p2_limit_d      = new_p2;
          p2_star_limit_d = new_p2_star;
        end else begin
          p2_limit_d      = p2_default_q;
          p2_star_limit_d = p2_star_default_q;
        end
      end
      dssc_pkg::CMD_HEARTBEAT: begin
        session_age_d = '0;
      end
      dssc_pkg::CMD_RESPONSE: begin
        if (pending_active_q && ((first_byte & ~dssc_pkg::RESPONSE_BIT) == pending_sid_q))
          pending_active_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.active_session = session_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_default_q      <= dssc_pkg::P2_DEFAULT_RST;
      p2_star_default_q <= dssc_pkg::P2_STAR_DEFAULT_RST;
      s3_limit_q        <= dssc_pkg::S3_LIMIT_RST;
      session_q         <= dssc_pkg::SESSION_DEFAULT;
      p2_limit_q        <= dssc_pkg::P2_DEFAULT_RST;
      p2_star_limit_q   <= dssc_pkg::P2_STAR_DEFAULT_RST;
      session_age_q     <= '0;
      pending_active_q  <= 1'b0;
      pending_sid_q     <= '0;
      pending_age_q     <= '0;
      p2_passed_q       <= 1'b0;
      out_valid_q       <= 1'b0;
      skid_valid_q      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_i)
          dssc_pkg::CFG_P2_DEFAULT:      p2_default_q      <= cfg_data_i;
          dssc_pkg::CFG_P2_STAR_DEFAULT: p2_star_default_q <= cfg_data_i;
          dssc_pkg::CFG_S3_LIMIT:        s3_limit_q        <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        session_q        <= session_d;
        p2_limit_q       <= p2_limit_d;
        p2_star_limit_q  <= p2_star_limit_d;
        session_age_q    <= session_age_d;
        pending_active_q <= pending_active_d;
        pending_sid_q    <= pending_sid_d;
        pending_age_q    <= pending_age_d;
        p2_passed_q      <= p2_passed_d;
      end
      // output register plus skid word
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_accept) begin
      if (!out_valid_q || out_take) out_q <= res_d;
      else skid_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_pending_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pending_active_q) |->
      $past(in_accept && s_axis_tuser_i == dssc_pkg::CMD_RESPONSE))
    else $error("pending record cleared without a response word");

  a_session_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(session_q) && session_q != dssc_pkg::SESSION_DEFAULT) |->
      $past(in_accept && s_axis_tuser_i == dssc_pkg::CMD_SET_SESSION))
    else $error("non-default session entered without a session change");

  a_p2_passed_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(p2_passed_q) |->
      $past(in_accept && s_axis_tuser_i == dssc_pkg::CMD_TICK && pending_active_q))
    else $error("P2 passed flag set outside a tick with a pending service");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_diag_session_service_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_diag_session_service_control
// Self-checking bench for the session and service gate. Events go in on the
// slave stream, a scoreboard predicts the result word of each accepted event
// and compares it with the master stream. Directed events first, then random
// event mixes under several limit settings, a back-to-back tick run with
// short reminder limits, and random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_diag_session_service_control;

  // Tracks session, limits and the pending service as the gate should.
  class session_gate_sb;
    logic [15:0] p2_dflt, p2s_dflt, s3_lim;
    logic [2:0]  sess;
    logic [15:0] p2_lim, p2s_lim, sess_age, pend_age;
    logic        pend_on, p2_over;
    logic [7:0]  pend_sid;
    dssc_pkg::result_t replies_due[$];
    int unsigned n_bad, n_seen, n_reminder, n_busy, n_unsup, n_refused, n_run, n_fallback;

    function new();
      p2_dflt    = dssc_pkg::P2_DEFAULT_RST;
      p2s_dflt   = dssc_pkg::P2_STAR_DEFAULT_RST;
      s3_lim     = dssc_pkg::S3_LIMIT_RST;
      sess       = dssc_pkg::SESSION_DEFAULT;
      p2_lim     = dssc_pkg::P2_DEFAULT_RST;
      p2s_lim    = dssc_pkg::P2_STAR_DEFAULT_RST;
      sess_age   = '0;
      pend_age   = '0;
      pend_on    = 1'b0;
      p2_over    = 1'b0;
      pend_sid   = '0;
      n_bad      = 0;
      n_seen     = 0;
      n_reminder = 0;
      n_busy     = 0;
      n_unsup    = 0;
      n_refused  = 0;
      n_run      = 0;
      n_fallback = 0;
    endfunction

    function void write_limit(logic [dssc_pkg::CFG_IDX_W-1:0] idx,
                              logic [dssc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        dssc_pkg::CFG_P2_DEFAULT:      p2_dflt = val;
        dssc_pkg::CFG_P2_STAR_DEFAULT: p2s_dflt = val;
        dssc_pkg::CFG_S3_LIMIT:        s3_lim = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] bump(logic [15:0] a);
      return (a == dssc_pkg::AGE_MAX) ? a : a + 16'd1;
    endfunction

    function void note_event(logic [2:0] cmd, logic [dssc_pkg::IN_DATA_W-1:0] d);
      dssc_pkg::result_t r;
      logic [7:0]  fb, mask;
      logic        known, outcome;
      logic [2:0]  ns;
      logic [15:0] np2, np2s;
      r       = '0;
      fb      = d[7:0];
      known   = d[8];
      mask    = d[16:9];
      outcome = d[17];
      ns      = d[20:18];
      np2     = d[36:21];
      np2s    = d[52:37];
      case (cmd)
        dssc_pkg::CMD_TICK: begin
          sess_age = bump(sess_age);
          pend_age = bump(pend_age);
          if (sess != dssc_pkg::SESSION_DEFAULT && sess_age >= s3_lim) begin
            sess    = dssc_pkg::SESSION_DEFAULT;
            p2_lim  = p2_dflt;
            p2s_lim = p2s_dflt;
            n_fallback++;
          end
          if (pend_on) begin
            // first reminder after P2, later ones after each P2*
            if (pend_age >= (p2_over ? p2s_lim : p2_lim)) begin
              p2_over    = 1'b1;
              r.send_nrc = 1'b1;
              r.nrc_code = dssc_pkg::NRC_PENDING;
              r.nrc_sid  = pend_sid;
              pend_age   = '0;
              n_reminder++;
            end
          end else begin
            p2_over = 1'b0;
          end
        end
        dssc_pkg::CMD_REQUEST: begin
          if (pend_on && fb != dssc_pkg::SID_TESTER_PRESENT) begin
            r.send_nrc = 1'b1;
            r.nrc_code = dssc_pkg::NRC_BUSY;
            r.nrc_sid  = fb;
            n_busy++;
          end else if (!known) begin
            r.send_nrc = 1'b1;
            r.nrc_code = dssc_pkg::NRC_NOT_SUPPORTED;
            r.nrc_sid  = fb;
            n_unsup++;
          end else if (mask[sess]) begin
            r.run_service = 1'b1;
            n_run++;
            if (outcome) begin
              pend_on  = 1'b1;
              pend_sid = fb;
              pend_age = '0;
            end
          end else begin
            r.send_nrc = 1'b1;
            r.nrc_code = dssc_pkg::NRC_NOT_IN_SESSION;
            r.nrc_sid  = fb;
            n_refused++;
          end
        end
        dssc_pkg::CMD_SET_SESSION: begin
          if (ns != dssc_pkg::SESSION_DEFAULT) begin
            sess_age = '0;
            p2_lim   = np2;
            p2s_lim  = np2s;
          end else begin
            p2_lim  = p2_dflt;
            p2s_lim = p2s_dflt;
          end
          sess = ns;
        end
        dssc_pkg::CMD_HEARTBEAT: sess_age = '0;
        dssc_pkg::CMD_RESPONSE: begin
          if (pend_on && (fb & ~dssc_pkg::RESPONSE_BIT) == pend_sid) pend_on = 1'b0;
        end
        default: ;
      endcase
      r.active_session = sess;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [dssc_pkg::OUT_DATA_W-1:0] w);
      dssc_pkg::result_t got, want;
      got = w[$bits(dssc_pkg::result_t)-1:0];
      if (replies_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h with nothing outstanding", w);
        return;
      end
      want = replies_due.pop_front();
      n_seen++;
      if (got.send_nrc !== want.send_nrc || got.nrc_code !== want.nrc_code ||
          got.nrc_sid !== want.nrc_sid || got.run_service !== want.run_service ||
          got.active_session !== want.active_session) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"word %0d mismatch: exp nrc=%b code=%h sid=%h run=%b sess=%0d,",
                    " got nrc=%b code=%h sid=%h run=%b sess=%0d"},
                   n_seen, want.send_nrc, want.nrc_code, want.nrc_sid, want.run_service,
                   want.active_session, got.send_nrc, got.nrc_code, got.nrc_sid,
                   got.run_service, got.active_session);
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [dssc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [2:0]                      s_axis_tuser_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  logic [dssc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [dssc_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [dssc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  session_gate_sb sb;
  logic           gap_on;
  logic           stall_on;

  diag_session_service_control DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) sb.note_event(s_axis_tuser_i, s_axis_tdata_i);
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_reply(m_axis_tdata_o);
    if (cfg_valid_i && cfg_ready_o) sb.write_limit(cfg_index_i, cfg_data_i);
  end

  // result side back-pressure in bursts
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #24_000_000;
    $display("tb_diag_session_service_control: errors");
    $finish;
  end

  function automatic logic [dssc_pkg::IN_DATA_W-1:0] event_word(logic [7:0] fb, logic known,
      logic [7:0] mask, logic outcome, logic [2:0] ns, logic [15:0] np2, logic [15:0] np2s);
    return {3'b000, np2s, np2, ns, outcome, mask, known, fb};
  endfunction

  task automatic push_event(input logic [2:0] cmd,
                            input logic [dssc_pkg::IN_DATA_W-1:0] d);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic sender_gap(input int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result word
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dssc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dssc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] p2d, input logic [15:0] p2sd,
                            input logic [15:0] s3);
    settle();
    write_reg(dssc_pkg::CFG_P2_DEFAULT, p2d);
    write_reg(dssc_pkg::CFG_P2_STAR_DEFAULT, p2sd);
    write_reg(dssc_pkg::CFG_S3_LIMIT, s3);
  endtask

  // mostly plausible traffic; unused fields carry random noise
  task automatic random_event();
    logic [2:0]  cmd;
    logic [7:0]  fb, mask;
    logic        known, outcome;
    logic [2:0]  ns;
    logic [15:0] np2, np2s;
    int unsigned pick;
    fb      = 8'($urandom);
    mask    = 8'($urandom);
    known   = 1'($urandom);
    outcome = 1'($urandom);
    ns      = 3'($urandom);
    np2     = 16'($urandom);
    np2s    = 16'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 42) begin
      cmd = dssc_pkg::CMD_TICK;
    end else if (pick < 72) begin
      cmd = dssc_pkg::CMD_REQUEST;
      case ($urandom_range(0, 6))
        0:       fb = dssc_pkg::SID_TESTER_PRESENT;
        1:       fb = sb.pend_sid;
        default: ;
      endcase
      known = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2: mask = 8'hFF;
        3, 4, 5: mask = 8'd1 << sb.sess;
        default: ;
      endcase
      outcome = ($urandom_range(0, 19) < 9);
    end else if (pick < 82) begin
      cmd = dssc_pkg::CMD_RESPONSE;
      if ($urandom_range(0, 3) != 0)
        fb = $urandom_range(0, 1) ? (sb.pend_sid | dssc_pkg::RESPONSE_BIT) : sb.pend_sid;
    end else if (pick < 90) begin
      cmd = dssc_pkg::CMD_SET_SESSION;
      ns  = ($urandom_range(0, 3) == 0) ? dssc_pkg::SESSION_DEFAULT
                                        : 3'($urandom_range(1, 7));
      if ($urandom_range(0, 4) != 0) np2 = 16'($urandom_range(0, 12));
      if ($urandom_range(0, 4) != 0) np2s = 16'($urandom_range(0, 12));
    end else if (pick < 97) begin
      cmd = dssc_pkg::CMD_HEARTBEAT;
    end else begin
      cmd = dssc_pkg::CMD_RESPONSE + 3'($urandom_range(1, 3));
    end
    push_event(cmd, event_word(fb, known, mask, outcome, ns, np2, np2s));
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      if (gap_on && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 8));
      if ($urandom_range(0, 59) == 0) settle();
      random_event();
    end
  endtask

  initial begin
    sb              = new();
    gap_on          = 1'b1;
    stall_on        = 1'b1;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = dssc_pkg::CMD_TICK;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = dssc_pkg::CFG_P2_DEFAULT;
    cfg_data_i      = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset limits
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h00, 1'b0, 8'hFF, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'hFF, 1'b1, 8'hFE, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h22, 1'b1, 8'h01, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_SET_SESSION,
               event_word(8'h00, 1'b0, 8'h00, 1'b0, 3'd7, 16'd1, 16'd2));
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h31, 1'b1, 8'h80, 1'b1, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h22, 1'b1, 8'hFF, 1'b0, 3'd0, 16'd0, 16'd0));
    // busy wins over an unknown service
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h55, 1'b0, 8'hFF, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_TICK, '0);
    // tester present gets through and takes over the pending slot
    push_event(dssc_pkg::CMD_REQUEST, event_word(dssc_pkg::SID_TESTER_PRESENT, 1'b1, 8'h80,
                                                 1'b1, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_RESPONSE,
               event_word(8'h71, 1'b0, 8'h00, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_RESPONSE,
               event_word(dssc_pkg::SID_TESTER_PRESENT | dssc_pkg::RESPONSE_BIT, 1'b0,
                          8'h00, 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_RESPONSE + 3'd3, {3'b000, {53{1'b1}}});
    push_event(dssc_pkg::CMD_REQUEST, event_word(dssc_pkg::SID_TESTER_PRESENT, 1'b1, 8'h7F,
                                                 1'b0, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_SET_SESSION,
               event_word(8'h00, 1'b0, 8'h00, 1'b0, dssc_pkg::SESSION_DEFAULT,
                          16'hFFFF, 16'hFFFF));
    push_event(dssc_pkg::CMD_REQUEST,
               event_word(8'h10, 1'b1, 8'h01, 1'b1, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_RESPONSE,
               event_word(8'h50, 1'b0, 8'h00, 1'b0, 3'd0, 16'd0, 16'd0));
    run_random(250);

    // directed: S3 fallback, heartbeat, zero P2
    set_limits(16'd0, 16'd1, 16'd2);
    push_event(dssc_pkg::CMD_SET_SESSION,
               event_word(8'h00, 1'b0, 8'h00, 1'b0, 3'd5, 16'hFFFF, 16'hFFFF));
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_HEARTBEAT, '0);
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_REQUEST, event_word(dssc_pkg::SID_TESTER_PRESENT, 1'b1, 8'h01,
                                                 1'b1, 3'd0, 16'd0, 16'd0));
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_RESPONSE, event_word(dssc_pkg::SID_TESTER_PRESENT, 1'b0, 8'h00,
                                                  1'b0, 3'd0, 16'd0, 16'd0));

    set_limits(16'd0, 16'd0, 16'd0);
    run_random(150);
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);

    // back-to-back ticks with a pending service and short reminder limits
    settle();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    push_event(dssc_pkg::CMD_SET_SESSION,
               event_word(8'h00, 1'b0, 8'h00, 1'b0, 3'd1, 16'd2, 16'd3));
    push_event(dssc_pkg::CMD_REQUEST, event_word(dssc_pkg::SID_TESTER_PRESENT, 1'b1, 8'h02,
                                                 1'b1, 3'd0, 16'd0, 16'd0));
    repeat (40) push_event(dssc_pkg::CMD_TICK, '0);
    push_event(dssc_pkg::CMD_RESPONSE,
               event_word(dssc_pkg::SID_TESTER_PRESENT | dssc_pkg::RESPONSE_BIT, 1'b0,
                          8'h00, 1'b0, 3'd0, 16'd0, 16'd0));

    set_limits(16'd3, 16'd7, 16'd25);
    gap_on   = 1'b1;
    stall_on = 1'b1;
    run_random(250);
    set_limits(16'd1, 16'd4, 16'd12);
    run_random(200);
    gap_on   = 1'b0;
    stall_on = 1'b0;
    run_random(200);

    settle();
    repeat (4) @(posedge clk_i);
    if (sb.replies_due.size() != 0) begin
      sb.n_bad++;
      $display("%0d result words never arrived", sb.replies_due.size());
    end
    $display("checked %0d result words over six limit settings and a back-to-back tick run",
             sb.n_seen);
    $display({"responses: %0d forwarded, %0d pending, %0d busy, %0d unsupported,",
              " %0d wrong session, %0d S3 fallbacks"},
             sb.n_run, sb.n_reminder, sb.n_busy, sb.n_unsup, sb.n_refused, sb.n_fallback);
    if (sb.n_bad == 0) begin
      $display("tb_diag_session_service_control: clean");
    end else begin
      $display("%0d failures", sb.n_bad);
      $display("tb_diag_session_service_control: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
